// ===== design/gsc_pkg.sv =====
package gsc_pkg;

    // glyph geometry and store layout
    localparam int MAX_GLYPH_WIDTH  = 8;
    localparam int MAX_GLYPH_HEIGHT = 8;
    localparam int GLYPH_COUNT      = 96;
    localparam int FIRST_CODE       = 32;
    localparam int SLOT_SIZE        = MAX_GLYPH_WIDTH * MAX_GLYPH_HEIGHT;
    localparam int STORE_DEPTH      = GLYPH_COUNT * SLOT_SIZE;

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int COL_W   = (MAX_GLYPH_WIDTH > 1) ? $clog2(MAX_GLYPH_WIDTH) : 1;
    localparam int ROW_W   = (MAX_GLYPH_HEIGHT > 1) ? $clog2(MAX_GLYPH_HEIGHT) : 1;
    localparam int GLYPH_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int DIMW_W  = $clog2(MAX_GLYPH_WIDTH + 1) + 1;
    localparam int DIMH_W  = $clog2(MAX_GLYPH_HEIGHT + 1) + 1;
    localparam int COLS_W  = $clog2(GLYPH_COUNT + 1);
    localparam int BASE_W  = $clog2(2 * GLYPH_COUNT + 1);

    // fixed field widths
    localparam int CFG_DIM_W  = 4;
    localparam int CFG_COLS_W = 7;
    localparam int CODE_W     = 8;
    localparam int PIX_W      = 8;
    localparam int ORG_W      = 10;
    localparam int POS_W      = 11;
    localparam int COLOR_W    = 8;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // input operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // register indexes
    localparam logic [1:0] REG_GLYPH_WIDTH   = 2'd0;
    localparam logic [1:0] REG_GLYPH_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CHARS_PER_ROW = 2'd2;

    typedef enum logic {
        DRAW_IDLE,
        DRAW_WALK
    } draw_state_t;

    typedef struct packed {
        logic [DIMW_W-1:0] gw;
        logic [DIMH_W-1:0] gh;
        logic [COLS_W-1:0] cols;
    } dims_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              data;
    } store_wr_t;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic [ORG_W-1:0]   ox;
        logic [ORG_W-1:0]   oy;
        logic [COLOR_W-1:0] ink;
    } draw_req_t;

    function automatic logic [DIMW_W-1:0] clamp_width(input logic [CFG_DIM_W-1:0] v);
        logic [DIMW_W-1:0] r;
        if (v == '0)
            r = DIMW_W'(1);
        else if (32'(v) > MAX_GLYPH_WIDTH)
            r = DIMW_W'(MAX_GLYPH_WIDTH);
        else
            r = DIMW_W'(v);
        return r;
    endfunction

    function automatic logic [DIMH_W-1:0] clamp_height(input logic [CFG_DIM_W-1:0] v);
        logic [DIMH_W-1:0] r;
        if (v == '0)
            r = DIMH_W'(1);
        else if (32'(v) > MAX_GLYPH_HEIGHT)
            r = DIMH_W'(MAX_GLYPH_HEIGHT);
        else
            r = DIMH_W'(v);
        return r;
    endfunction

    function automatic logic [COLS_W-1:0] clamp_cols(input logic [CFG_COLS_W-1:0] v);
        logic [COLS_W-1:0] r;
        if (v == '0)
            r = COLS_W'(1);
        else if (32'(v) > GLYPH_COUNT)
            r = COLS_W'(GLYPH_COUNT);
        else
            r = COLS_W'(v);
        return r;
    endfunction

endpackage

// ===== design/gsc_store.sv =====
module gsc_store (
    input  logic                           clk,
    input  gsc_pkg::store_wr_t             wr,
    input  logic                           rd_en,
    input  logic [gsc_pkg::ADDR_W-1:0]     rd_addr,
    output logic                           rd_data
);

    logic mem [gsc_pkg::STORE_DEPTH];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/gsc_loader.sv =====
module gsc_loader (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           restart,
    input  logic                           load_en,
    input  logic [gsc_pkg::PIX_W-1:0]      pixel_value,
    input  gsc_pkg::dims_t                 dims,
    output gsc_pkg::store_wr_t             wr
);

    logic [gsc_pkg::COL_W-1:0]  col_in_glyph_reg, col_in_glyph_next;
    logic [gsc_pkg::COLS_W-1:0] glyph_col_reg, glyph_col_next;
    logic [gsc_pkg::ROW_W-1:0]  row_in_glyph_reg, row_in_glyph_next;
    // first glyph index of the current sheet row (glyph row times columns)
    logic [gsc_pkg::BASE_W-1:0] row_base_reg, row_base_next;

    logic [gsc_pkg::BASE_W-1:0] glyph;
    logic [gsc_pkg::BASE_W-1:0] base_step;
    logic                       col_wrap, gcol_wrap, row_wrap, base_wrap;

    assign glyph     = row_base_reg + gsc_pkg::BASE_W'(glyph_col_reg);
    assign base_step = row_base_reg + gsc_pkg::BASE_W'(dims.cols);

    assign col_wrap  = (gsc_pkg::DIMW_W'(col_in_glyph_reg) + gsc_pkg::DIMW_W'(1)) >= dims.gw;
    assign gcol_wrap = (gsc_pkg::COLS_W'(glyph_col_reg + gsc_pkg::COLS_W'(1))) >= dims.cols;
    assign row_wrap  = (gsc_pkg::DIMH_W'(row_in_glyph_reg) + gsc_pkg::DIMH_W'(1)) >= dims.gh;
    assign base_wrap = 32'(base_step) >= gsc_pkg::GLYPH_COUNT;

    always_comb
    begin
        wr.en   = load_en && (32'(glyph) < gsc_pkg::GLYPH_COUNT);
        wr.addr = gsc_pkg::ADDR_W'(glyph) * gsc_pkg::ADDR_W'(gsc_pkg::SLOT_SIZE)
                + gsc_pkg::ADDR_W'(row_in_glyph_reg)
                  * gsc_pkg::ADDR_W'(gsc_pkg::MAX_GLYPH_WIDTH)
                + gsc_pkg::ADDR_W'(col_in_glyph_reg);
        wr.data = (pixel_value != '0);
    end

    always_comb
    begin
        col_in_glyph_next = col_in_glyph_reg;
        glyph_col_next    = glyph_col_reg;
        row_in_glyph_next = row_in_glyph_reg;
        row_base_next     = row_base_reg;
        if (restart)
        begin
            col_in_glyph_next = '0;
            glyph_col_next    = '0;
            row_in_glyph_next = '0;
            row_base_next     = '0;
        end
        else if (load_en)
        begin
            col_in_glyph_next = col_in_glyph_reg + gsc_pkg::COL_W'(1);
            if (col_wrap)
            begin
                col_in_glyph_next = '0;
                glyph_col_next    = glyph_col_reg + gsc_pkg::COLS_W'(1);
                if (gcol_wrap)
                begin
                    glyph_col_next    = '0;
                    row_in_glyph_next = row_in_glyph_reg + gsc_pkg::ROW_W'(1);
                    if (row_wrap)
                    begin
                        row_in_glyph_next = '0;
                        row_base_next     = base_wrap ? '0 : base_step;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_in_glyph_reg <= '0;
            glyph_col_reg    <= '0;
            row_in_glyph_reg <= '0;
            row_base_reg     <= '0;
        end
        else
        begin
            col_in_glyph_reg <= col_in_glyph_next;
            glyph_col_reg    <= glyph_col_next;
            row_in_glyph_reg <= row_in_glyph_next;
            row_base_reg     <= row_base_next;
        end
    end

endmodule

// ===== design/gsc_draw.sv =====
module gsc_draw (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  gsc_pkg::draw_req_t             req,
    input  gsc_pkg::dims_t                 dims,
    output logic                           busy,
    output logic                           rd_en,
    output logic [gsc_pkg::ADDR_W-1:0]     rd_addr,
    input  logic                           rd_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [gsc_pkg::POS_W-1:0]      pixel_x,
    output logic [gsc_pkg::POS_W-1:0]      pixel_y,
    output logic [gsc_pkg::COLOR_W-1:0]    pixel_color,
    output logic                           draw,
    output logic                           last
);

    gsc_pkg::draw_state_t state_reg, state_next;

    logic [gsc_pkg::GLYPH_W-1:0] glyph_reg;
    logic [gsc_pkg::ORG_W-1:0]   ox_reg, oy_reg;
    logic [gsc_pkg::COLOR_W-1:0] ink_reg;
    logic [gsc_pkg::COL_W-1:0]   col_reg, col_next;
    logic [gsc_pkg::ROW_W-1:0]   row_reg, row_next;

    // read stage, aligned with the store read data
    logic                        s1_valid_reg, s1_valid_next;
    logic [gsc_pkg::POS_W-1:0]   s1_x_reg, s1_y_reg;
    logic [gsc_pkg::COLOR_W-1:0] s1_ink_reg;
    logic                        s1_last_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [gsc_pkg::POS_W-1:0]   out_x_reg, out_y_reg;
    logic [gsc_pkg::COLOR_W-1:0] out_color_reg;
    logic                        out_draw_reg, out_last_reg;

    logic col_last, row_last, pix_last, issue, s1_adv;

    assign col_last = (gsc_pkg::DIMW_W'(col_reg) + gsc_pkg::DIMW_W'(1)) == dims.gw;
    assign row_last = (gsc_pkg::DIMH_W'(row_reg) + gsc_pkg::DIMH_W'(1)) == dims.gh;
    assign pix_last = col_last && row_last;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign issue  = (state_reg == gsc_pkg::DRAW_WALK) && (!s1_valid_reg || s1_adv);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gsc_pkg::DRAW_IDLE:
            begin
                if (start)
                    state_next = gsc_pkg::DRAW_WALK;
            end
            gsc_pkg::DRAW_WALK:
            begin
                if (issue && pix_last)
                    state_next = gsc_pkg::DRAW_IDLE;
            end
            default:
            begin
                state_next = gsc_pkg::DRAW_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy    = (state_reg == gsc_pkg::DRAW_WALK);
        rd_en   = issue;
        rd_addr = gsc_pkg::ADDR_W'(glyph_reg) * gsc_pkg::ADDR_W'(gsc_pkg::SLOT_SIZE)
                + gsc_pkg::ADDR_W'(row_reg) * gsc_pkg::ADDR_W'(gsc_pkg::MAX_GLYPH_WIDTH)
                + gsc_pkg::ADDR_W'(col_reg);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (start)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (issue)
        begin
            col_next = col_reg + gsc_pkg::COL_W'(1);
            if (col_last)
            begin
                col_next = '0;
                row_next = row_reg + gsc_pkg::ROW_W'(1);
            end
        end
    end

    assign s1_valid_next  = issue ? 1'b1 : (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gsc_pkg::DRAW_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            glyph_reg <= req.glyph;
            ox_reg    <= req.ox;
            oy_reg    <= req.oy;
            ink_reg   <= req.ink;
        end
        if (issue)
        begin
            s1_x_reg    <= gsc_pkg::POS_W'(ox_reg) + gsc_pkg::POS_W'(col_reg);
            s1_y_reg    <= gsc_pkg::POS_W'(oy_reg) + gsc_pkg::POS_W'(row_reg);
            s1_ink_reg  <= ink_reg;
            s1_last_reg <= pix_last;
        end
        if (s1_adv)
        begin
            out_x_reg     <= s1_x_reg;
            out_y_reg     <= s1_y_reg;
            out_color_reg <= rd_data ? s1_ink_reg : '0;
            out_draw_reg  <= rd_data;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign pixel_color = out_color_reg;
    assign draw        = out_draw_reg;
    assign last        = out_last_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == gsc_pkg::DRAW_IDLE)
        else $error("draw started while a glyph walk is running");

    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        issue && pix_last |=> state_reg == gsc_pkg::DRAW_IDLE)
        else $error("walk did not end after the final glyph pixel");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_x_reg)
            && $stable(s1_y_reg) && $stable(s1_last_reg) && !$past(issue))
        else $error("read stage lost or overwrote a held pixel");

    a_blank_color: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_draw_reg |-> out_color_reg == '0)
        else $error("unset pixel carries a color");

endmodule

// ===== design/glyph_sheet_char_generator_core.sv =====
// bitmap font character generator
//
// input channel (in_valid / in_stall): op selects a load or a draw. a load
// transfer carries one font sheet pixel in raster order; the sheet pixels are
// re-sorted into a one-bit glyph store, nonzero meaning set, and pixels of
// slots past the last glyph are dropped. loads give no output. a draw
// transfer carries char_code, origin_x, origin_y and ink_color; codes
// outside the printable range draw the space glyph.
// output channel (out_valid / out_stall): a draw gives glyph_width x
// glyph_height transfers in row-major order with screen position, color,
// draw flag and last on the final pixel.
// a draw transfer starts the pixel walk: each pixel is read from the store
// into the read stage, then registered at the output. the store read port
// delivers one pixel per cycle while the receiver keeps up, and a draw holds
// the input until its last pixel is read. a stalled receiver freezes the
// output register and the read stage behind it, and the walk waits with them.
// reset clears the load position, the pixel walk and both valid stages and
// sets the registers to 8 x 8 glyphs, 16 per sheet row. the glyph store is
// not cleared: load every glyph before drawing it. a write over the apb
// port to a used register restarts the load position at the sheet's top left.
module glyph_sheet_char_generator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gsc_pkg::PADDR_W-1:0]         paddr,
    input  logic [gsc_pkg::PDATA_W-1:0]         pwdata,
    output logic [gsc_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [gsc_pkg::PIX_W-1:0]           pixel_value,
    input  logic [gsc_pkg::CODE_W-1:0]          char_code,
    input  logic [gsc_pkg::ORG_W-1:0]           origin_x,
    input  logic [gsc_pkg::ORG_W-1:0]           origin_y,
    input  logic [gsc_pkg::COLOR_W-1:0]         ink_color,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [gsc_pkg::POS_W-1:0]           pixel_x,
    output logic [gsc_pkg::POS_W-1:0]           pixel_y,
    output logic [gsc_pkg::COLOR_W-1:0]         pixel_color,
    output logic                                draw,
    output logic                                last
);

    // configuration registers, kept as written
    logic [gsc_pkg::CFG_DIM_W-1:0]  glyph_width_reg;
    logic [gsc_pkg::CFG_DIM_W-1:0]  glyph_height_reg;
    logic [gsc_pkg::CFG_COLS_W-1:0] chars_per_row_reg;

    logic                      cfg_wr;
    logic [1:0]                reg_idx;
    logic                      restart;
    gsc_pkg::dims_t            dims;
    logic                      in_xfer, load_en, draw_start, busy;
    logic [gsc_pkg::CODE_W-1:0] code_off;
    gsc_pkg::draw_req_t        req;
    gsc_pkg::store_wr_t        wr;
    logic                      rd_en, rd_data;
    logic [gsc_pkg::ADDR_W-1:0] rd_addr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register decode: writes to unused addresses are dropped
    always_comb
    begin
        restart = 1'b0;
        prdata  = '0;
        unique case (reg_idx)
            gsc_pkg::REG_GLYPH_WIDTH:
            begin
                restart = cfg_wr;
                prdata  = gsc_pkg::PDATA_W'(glyph_width_reg);
            end
            gsc_pkg::REG_GLYPH_HEIGHT:
            begin
                restart = cfg_wr;
                prdata  = gsc_pkg::PDATA_W'(glyph_height_reg);
            end
            gsc_pkg::REG_CHARS_PER_ROW:
            begin
                restart = cfg_wr;
                prdata  = gsc_pkg::PDATA_W'(chars_per_row_reg);
            end
            default:
            begin
                restart = 1'b0;
                prdata  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_width_reg   <= gsc_pkg::CFG_DIM_W'(8);
            glyph_height_reg  <= gsc_pkg::CFG_DIM_W'(8);
            chars_per_row_reg <= gsc_pkg::CFG_COLS_W'(16);
        end
        else if (cfg_wr)
        begin
            if (reg_idx == gsc_pkg::REG_GLYPH_WIDTH)
                glyph_width_reg <= pwdata[gsc_pkg::CFG_DIM_W-1:0];
            if (reg_idx == gsc_pkg::REG_GLYPH_HEIGHT)
                glyph_height_reg <= pwdata[gsc_pkg::CFG_DIM_W-1:0];
            if (reg_idx == gsc_pkg::REG_CHARS_PER_ROW)
                chars_per_row_reg <= pwdata[gsc_pkg::CFG_COLS_W-1:0];
        end
    end

    // out-of-range sizes are clamped to the legal range
    assign dims.gw   = gsc_pkg::clamp_width(glyph_width_reg);
    assign dims.gh   = gsc_pkg::clamp_height(glyph_height_reg);
    assign dims.cols = gsc_pkg::clamp_cols(chars_per_row_reg);

    // the input is held while a glyph walk owns the store read port
    assign in_stall   = busy;
    assign in_xfer    = in_valid && !in_stall;
    assign load_en    = in_xfer && (op == gsc_pkg::OP_LOAD);
    assign draw_start = in_xfer && (op == gsc_pkg::OP_DRAW);

    // code to glyph slot, unprintable codes fall back to the space
    assign code_off = char_code - gsc_pkg::CODE_W'(gsc_pkg::FIRST_CODE);
    always_comb
    begin
        req.ox  = origin_x;
        req.oy  = origin_y;
        req.ink = ink_color;
        if (32'(char_code) >= gsc_pkg::FIRST_CODE && 32'(code_off) < gsc_pkg::GLYPH_COUNT)
            req.glyph = gsc_pkg::GLYPH_W'(code_off);
        else
            req.glyph = '0;
    end

    gsc_loader u_loader (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (restart),
        .load_en     (load_en),
        .pixel_value (pixel_value),
        .dims        (dims),
        .wr          (wr)
    );

    // loads and reads never meet: loads are only taken between walks
    gsc_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gsc_draw u_draw (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (draw_start),
        .req         (req),
        .dims        (dims),
        .busy        (busy),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .draw        (draw),
        .last        (last)
    );

endmodule
